// ----- sv/range_to_seven_segment_display_top_assert.svh -----
// Assertion macros shared by the range display RTL.
`ifndef RANGE_TO_SEVEN_SEGMENT_DISPLAY_TOP_ASSERT_SVH
`define RANGE_TO_SEVEN_SEGMENT_DISPLAY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every rising clk edge, off while rst_n is low.
`define R7SEG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("r7seg assertion failed");
// Same-cycle implication.
`define R7SEG_ASSERT_IMP(lbl, ante, cons) \
  `R7SEG_ASSERT(lbl, (ante) |-> (cons))
`else
`define R7SEG_ASSERT(lbl, prop)
`define R7SEG_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- sv/r7seg_pkg.sv -----
// Types, constants and the segment encoder for the range display.
package r7seg_pkg;

  localparam int TICKS_W = 24;
  localparam int VAL_W   = 14;
  localparam int SEG_W   = 7;

  // Operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_RUN    = 2'd1;
  localparam logic [1:0] OP_UNIT   = 2'd2;

  // ticks*17 at or above this means more than 9999 mm
  localparam logic [28:0] SAT_LIMIT = 29'd50_000_000;
  // floor(y/625) = (y*MM_RECIP) >> 32 for y below 6.25e6
  localparam logic [22:0] MM_RECIP   = 23'd6_871_948;
  // floor(z/127) = (z*INCH_RECIP) >> 24 for z below 50000
  localparam logic [17:0] INCH_RECIP = 18'd132_105;
  // floor(v/100) = (v*HUND_RECIP) >> 20 for v below 10000
  localparam logic [13:0] HUND_RECIP = 14'd10_486;
  // floor(x/10) = (x*TEN_RECIP) >> 11 for x below 1024
  localparam logic [7:0]  TEN_RECIP  = 8'd205;
  localparam logic [VAL_W-1:0] DISP_MAX = 14'd9999;

  typedef struct packed {
    logic [1:0]         operation;
    logic [TICKS_W-1:0] echo_ticks;
  } r7seg_in_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg_ones;
    logic [SEG_W-1:0] seg_tens;
    logic [SEG_W-1:0] seg_hundreds;
    logic [SEG_W-1:0] seg_thousands;
  } r7seg_out_t;

  // Display value handed from the scaler to the digit encoder
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } r7seg_val_t;

  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- sv/r7seg_scale.sv -----
// Tick count to display value: mm scaling, clamp and inch conversion.
module r7seg_scale
  import r7seg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               smp_valid,
  input  logic [TICKS_W-1:0] smp_ticks,
  input  logic               smp_inch,
  output logic               smp_ready,
  output r7seg_val_t         val_o,
  input  logic               dn_ready
);

  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic               rdy1, rdy2, rdy3, rdy4;
  logic [TICKS_W-1:0] s1_ticks_r;
  logic               s1_inch_r, s2_inch_r, s3_inch_r;
  logic [22:0]        s2_y_r, s2_y_nxt;
  logic               s2_sat_r, s3_sat_r, s2_sat_nxt;
  logic [VAL_W-1:0]   s3_mm_r, s3_mm_nxt;
  logic [VAL_W-1:0]   s4_val_r, s4_val_nxt;
  logic [28:0]        x17;
  logic [45:0]        mm_prod;
  logic [15:0]        mm5;
  logic [33:0]        inch_prod;

  // a stage may load when it is empty or its contents move on
  assign rdy4      = !s4_v_r || dn_ready;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign smp_ready = rdy1;

  // ticks*17, then /5000 = (>>3)/625
  assign x17        = {1'b0, s1_ticks_r, 4'b0} + {5'b0, s1_ticks_r};
  assign s2_sat_nxt = (x17 >= SAT_LIMIT);
  assign s2_y_nxt   = x17[25:3];

  assign mm_prod   = 46'(s2_y_r) * 46'(MM_RECIP);
  assign s3_mm_nxt = mm_prod[45:32];

  assign mm5       = {s3_mm_r, 2'b0} + {2'b0, s3_mm_r};
  assign inch_prod = 34'(mm5) * 34'(INCH_RECIP);

  always_comb begin
    if (s3_sat_r) begin
      s4_val_nxt = DISP_MAX;
    end else if (s3_inch_r) begin
      s4_val_nxt = {4'b0, inch_prod[33:24]};
    end else begin
      s4_val_nxt = s3_mm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= smp_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && smp_valid) begin
      s1_ticks_r <= smp_ticks;
      s1_inch_r  <= smp_inch;
    end
    if (rdy2 && s1_v_r) begin
      s2_y_r    <= s2_y_nxt;
      s2_sat_r  <= s2_sat_nxt;
      s2_inch_r <= s1_inch_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_mm_r   <= s3_mm_nxt;
      s3_sat_r  <= s2_sat_r;
      s3_inch_r <= s2_inch_r;
    end
    if (rdy4 && s3_v_r) begin
      s4_val_r <= s4_val_nxt;
    end
  end

  assign val_o = '{valid: s4_v_r, value: s4_val_r};

endmodule

// ----- sv/r7seg_digits.sv -----
// Display value to four blanked seven-segment digits, with output register.
`include "range_to_seven_segment_display_top_assert.svh"
module r7seg_digits
  import r7seg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  r7seg_val_t val_i,
  output logic       up_ready,
  output logic       out_valid,
  output r7seg_out_t out_data,
  input  logic       out_stall
);

  // split x below 100 into tens and ones
  function automatic logic [7:0] split_tens(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = 15'(x) * 15'(TEN_RECIP);
    t = p[14:11];
    o = x - 7'({t, 3'b0} + {2'b0, t, 1'b0});
    return {t, o[3:0]};
  endfunction

  logic             s5_v_r, out_v_r;
  logic             rdy5, rdy_out;
  logic [6:0]       s5_hi_r, s5_lo_r, hi_nxt, lo_nxt;
  logic [27:0]      hund_prod;
  logic [VAL_W-1:0] hund_x100;
  logic [7:0]       hi_dig, lo_dig;
  logic [3:0]       d0, d1, d2, d3;
  r7seg_out_t       out_r, out_nxt;

  assign rdy_out  = !out_v_r || !out_stall;
  assign rdy5     = !s5_v_r || rdy_out;
  assign up_ready = rdy5;

  // value = hi*100 + lo
  assign hund_prod = 28'(val_i.value) * 28'(HUND_RECIP);
  assign hi_nxt    = hund_prod[26:20];
  assign hund_x100 = VAL_W'({hi_nxt, 6'b0}) + VAL_W'({hi_nxt, 5'b0}) + VAL_W'({hi_nxt, 2'b0});
  assign lo_nxt    = 7'(val_i.value - hund_x100);

  assign lo_dig = split_tens(s5_lo_r);
  assign hi_dig = split_tens(s5_hi_r);
  assign d0 = lo_dig[3:0];
  assign d1 = lo_dig[7:4];
  assign d2 = hi_dig[3:0];
  assign d3 = hi_dig[7:4];

  // leading zeros blank; ones always lit
  always_comb begin
    out_nxt.seg_ones      = seg_encode(d0);
    out_nxt.seg_tens      = ((d1 | d2 | d3) != 4'd0) ? seg_encode(d1) : '0;
    out_nxt.seg_hundreds  = ((d2 | d3) != 4'd0) ? seg_encode(d2) : '0;
    out_nxt.seg_thousands = (d3 != 4'd0) ? seg_encode(d3) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy5)    s5_v_r  <= val_i.valid;
      if (rdy_out) out_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && val_i.valid) begin
      s5_hi_r <= hi_nxt;
      s5_lo_r <= lo_nxt;
    end
    if (rdy_out && s5_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `R7SEG_ASSERT_IMP(a_ones_lit, out_v_r, out_r.seg_ones != 7'd0)
  `R7SEG_ASSERT_IMP(a_thou_blank, out_v_r && out_r.seg_thousands != 7'd0, out_r.seg_hundreds != 7'd0 && out_r.seg_tens != 7'd0)
  `R7SEG_ASSERT_IMP(a_hund_blank, out_v_r && out_r.seg_hundreds != 7'd0, out_r.seg_tens != 7'd0)

endmodule

// ----- sv/range_to_seven_segment_display_top.sv -----
// A distance word passes through the registered stages below, in order, before it shows on out_valid.
// Throughput: one word per cycle while in_stall is low; buttons and paused samples give no result.
// Stages: input, x17/clamp, /5000 multiply, inch multiply, /100 split, segments.
// Reset (synchronous, rst_n low): paused, mm units, pipeline empty.
// in_stall rises only when every stage is full and out_stall holds the output.
`include "range_to_seven_segment_display_top_assert.svh"
module range_to_seven_segment_display_top
  import r7seg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  r7seg_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output r7seg_out_t out_data
);

  logic       running_r, running_nxt;
  logic       inch_r, inch_nxt;
  logic       accept;
  logic       smp_valid, smp_ready;
  logic       enc_ready;
  r7seg_val_t scaled;

  // Every word goes through the same handshake; the input stage is the
  // first pipeline register, so stall only when it cannot move.
  assign in_stall = !smp_ready;
  assign accept   = in_valid && !in_stall;

  // Samples enter the pipeline only while running; they carry the unit
  // flag along, so later button words never change a word already inside.
  assign smp_valid = accept && (in_data.operation == OP_SAMPLE) && running_r;

  always_comb begin
    running_nxt = running_r;
    inch_nxt    = inch_r;
    if (accept) begin
      case (in_data.operation)
        OP_RUN:  running_nxt = !running_r;
        OP_UNIT: inch_nxt    = !inch_r;
        default: ;  // samples and the unused code leave the flags alone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      inch_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      inch_r    <= inch_nxt;
    end
  end

  // ticks -> mm -> clamp / inch conversion
  r7seg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_ticks (in_data.echo_ticks),
    .smp_inch  (inch_r),
    .smp_ready (smp_ready),
    .val_o     (scaled),
    .dn_ready  (enc_ready)
  );

  // value -> blanked segment patterns, holds the output word
  r7seg_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .val_i     (scaled),
    .up_ready  (enc_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  `R7SEG_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall)
  `R7SEG_ASSERT(a_run_toggle, accept && in_data.operation == OP_RUN |=> running_r != $past(running_r))
  `R7SEG_ASSERT(a_unit_toggle, accept && in_data.operation == OP_UNIT |=> inch_r != $past(inch_r))

endmodule
